// ----- rtl/kmc_pkg.sv -----
package kmc_pkg;

    // Fixed upper bounds that size the chain payload
    localparam int LBL_W  = 6;   // label bits, enough for 64 clusters
    localparam int ADDR_W = 20;  // pixel address bits, enough for 2^20 pixels
    localparam int DIST_W = 18;  // sum of three 8-bit squared differences
    localparam int KCNT_W = 7;   // active cluster count, up to 64

    // Configuration register indexes
    localparam logic [1:0] REG_CLUSTER_COUNT   = 2'd0;
    localparam logic [1:0] REG_ITERATION_LIMIT = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd2;
    localparam logic [1:0] REG_PIXEL_TOTAL     = 2'd3;

    typedef enum logic [2:0] {
        ACT_LOAD_PIX  = 3'd0,
        ACT_LOAD_CENT = 3'd1,
        ACT_RUN       = 3'd2,
        ACT_READ_PIX  = 3'd3,
        ACT_READ_CENT = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        KIND_LABEL = 2'd0,
        KIND_COLOR = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_LBL,
        ST_RD_DIV,
        ST_PASS_INIT,
        ST_FEED,
        ST_DRAIN,
        ST_UPD_SEL,
        ST_UPD_START,
        ST_UPD_WAIT,
        ST_RESP
    } state_t;

    // Pixel moving down the nearest-centroid search lane
    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] addr;
        logic [23:0]       rgb;
        logic [DIST_W-1:0] dsq;
        logic [LBL_W-1:0]  label;
    } srch_t;

    // Labeled pixel moving down the accumulate lane
    typedef struct packed {
        logic             vld;
        logic [LBL_W-1:0] label;
        logic [23:0]      rgb;
    } acc_t;

endpackage

// ----- rtl/kmc_div.sv -----
module kmc_div #(
    parameter int NW = 25,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [NW-1:0] quot,
    output logic [DW-1:0] rem
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[NW-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ----- rtl/kmc_cell.sv -----
module kmc_cell #(
    parameter int CNT_W = 17,
    parameter int SUM_W = 25
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [kmc_pkg::LBL_W-1:0] cell_idx,
    input  logic [kmc_pkg::KCNT_W-1:0] active_count,
    input  logic                      clr,
    input  logic                      cent_we,
    input  logic [23:0]               cent_wdata,
    input  kmc_pkg::srch_t            srch_in,
    output kmc_pkg::srch_t            srch_out,
    input  kmc_pkg::acc_t             acc_in,
    output kmc_pkg::acc_t             acc_out,
    output logic [23:0]               centroid,
    output logic [CNT_W-1:0]          member_cnt,
    output logic [SUM_W-1:0]          sum_r,
    output logic [SUM_W-1:0]          sum_g,
    output logic [SUM_W-1:0]          sum_b
);

    logic [23:0]        cent_reg;
    kmc_pkg::srch_t     s1_reg;
    kmc_pkg::srch_t     s2_reg, s2_next;
    logic [15:0]        sq_reg [3];
    logic [15:0]        sq_next [3];
    kmc_pkg::acc_t      acc_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   sum_reg [3];
    logic [SUM_W-1:0]   sum_next [3];
    logic [kmc_pkg::DIST_W-1:0] dsq_sum;
    logic               take;
    logic               hit;

    // Stage 1: squared channel differences to this centroid
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [7:0] a;
            logic [7:0] b;
            logic [7:0] d;
            a = srch_in.rgb[23-8*ch -: 8];
            b = cent_reg[23-8*ch -: 8];
            d = (a > b) ? (a - b) : (b - a);
            sq_next[ch] = 16'(d) * 16'(d);
        end
    end

    // Stage 2: keep the nearer centroid, lower index wins ties
    always_comb
    begin
        dsq_sum = kmc_pkg::DIST_W'(sq_reg[0]) + kmc_pkg::DIST_W'(sq_reg[1])
                + kmc_pkg::DIST_W'(sq_reg[2]);
        take = ({1'b0, cell_idx} < active_count) &&
               ((cell_idx == '0) || (dsq_sum < s1_reg.dsq));
        s2_next = s1_reg;
        if (take)
        begin
            s2_next.dsq   = dsq_sum;
            s2_next.label = cell_idx;
        end
    end

    // Accumulate member count and channel sums for pixels labeled here
    always_comb
    begin
        hit      = acc_in.vld && (acc_in.label == cell_idx);
        cnt_next = cnt_reg;
        for (int ch = 0; ch < 3; ch++)
            sum_next[ch] = sum_reg[ch];
        if (clr)
        begin
            cnt_next = '0;
            for (int ch = 0; ch < 3; ch++)
                sum_next[ch] = '0;
        end
        else if (hit)
        begin
            cnt_next = cnt_reg + 1'b1;
            for (int ch = 0; ch < 3; ch++)
                sum_next[ch] = sum_reg[ch] + SUM_W'(acc_in.rgb[23-8*ch -: 8]);
        end
    end

    // Lane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg  <= '0;
            s2_reg  <= '0;
            acc_reg <= '0;
        end
        else
        begin
            s1_reg  <= srch_in;
            s2_reg  <= s2_next;
            acc_reg <= acc_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            sq_reg[ch]  <= sq_next[ch];
            sum_reg[ch] <= sum_next[ch];
        end
        cnt_reg <= cnt_next;
        if (cent_we)
            cent_reg <= cent_wdata;
    end

    assign srch_out   = s2_reg;
    assign acc_out    = acc_reg;
    assign centroid   = cent_reg;
    assign member_cnt = cnt_reg;
    assign sum_r      = sum_reg[0];
    assign sum_g      = sum_reg[1];
    assign sum_b      = sum_reg[2];

endmodule

// ----- rtl/kmeans_color_clustering_unit.sv -----
// K-means color clustering over an RGB8 image held in on-chip memory. Pixels and
// starting centroids are loaded by index (one request per cycle); a run request
// performs iteration_limit Lloyd passes and answers with one run-finished result.
// Each pass streams the pixels one per cycle through a row of MAX_CLUSTERS cells
// (the nearest-centroid search through the stage-1 and stage-2 registers of each
// cell, the per-cluster sums through its accumulate lane register), then updates
// each non-empty centroid with a shared bit-serial divider whose dividend is NW =
// max(SUM_W, 16) bits wide, with SUM_W = 8 + clog2(MAX_PIXELS+1). A pixel read
// forms column and row with the same divider, which it skips when the image
// width is zero. After reset the label memory is cleared one entry per cycle,
// over all MAX_PIXELS entries, during which no request is accepted;
// configuration writes are taken.
module kmeans_color_clustering_unit #(
    parameter int MAX_PIXELS   = 65536,
    parameter int MAX_CLUSTERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    // Request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // item_index, in_red, in_green, in_blue
    input  logic [2:0]  s_axis_tuser,  // action
    // Result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // cluster_label, pixel_column, pixel_row,
                                       // out_red, out_green, out_blue, zero pad
    output logic [1:0]  m_axis_tuser   // result_kind
);

    localparam int PAW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W = 8 + CNT_W;
    localparam int NW    = (SUM_W > 16) ? SUM_W : 16;
    localparam int DW    = (CNT_W > 17) ? CNT_W : 17;
    localparam int DRAIN_CYC = 3 * MAX_CLUSTERS + 4;
    localparam int DRN_W = $clog2(DRAIN_CYC + 1);
    localparam int KW    = kmc_pkg::KCNT_W;

    // Configuration registers
    logic [4:0]  cluster_count_reg;
    logic [7:0]  iteration_limit_reg;
    logic [16:0] image_width_reg;
    logic [16:0] pixel_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg   <= 5'd4;
            iteration_limit_reg <= 8'd10;
            image_width_reg     <= 17'd256;
            pixel_total_reg     <= 17'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kmc_pkg::REG_CLUSTER_COUNT:   cluster_count_reg   <= cfg_wdata[4:0];
                kmc_pkg::REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_wdata[7:0];
                kmc_pkg::REG_IMAGE_WIDTH:     image_width_reg     <= cfg_wdata;
                kmc_pkg::REG_PIXEL_TOTAL:     pixel_total_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request fields
    logic [15:0]      in_idx;
    logic [23:0]      in_rgb;
    kmc_pkg::action_t in_act;
    logic             in_acc;

    assign in_idx = s_axis_tdata[15:0];
    assign in_rgb = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
    assign in_act = kmc_pkg::action_t'(s_axis_tuser);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Clamped cluster count and pixel count
    logic [KW-1:0]    kk;
    logic [CNT_W-1:0] npix;

    always_comb
    begin
        if (cluster_count_reg == '0)
            kk = KW'(1);
        else if (32'(cluster_count_reg) > MAX_CLUSTERS)
            kk = KW'(MAX_CLUSTERS);
        else
            kk = KW'(cluster_count_reg);
        if (32'(pixel_total_reg) > MAX_PIXELS)
            npix = CNT_W'(MAX_PIXELS);
        else
            npix = CNT_W'(pixel_total_reg);
    end

    // Control and datapath registers
    kmc_pkg::state_t  state_reg, state_next;
    logic [PAW-1:0]   clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0] feed_reg, feed_next;
    logic [DRN_W-1:0] drain_reg, drain_next;
    logic [7:0]       iter_reg, iter_next;
    logic [KW-1:0]    u_reg, u_next;
    logic [1:0]       ch_reg, ch_next;
    logic [15:0]      idx_reg, idx_next;
    logic [23:0]      newc_reg, newc_next;
    logic             rd_vld_reg;
    logic [PAW-1:0]   rd_addr_reg;

    logic [1:0]       res_kind_reg, res_kind_next;
    logic [3:0]       res_label_reg, res_label_next;
    logic [15:0]      res_col_reg, res_col_next;
    logic [15:0]      res_row_reg, res_row_next;
    logic [23:0]      res_rgb_reg, res_rgb_next;

    logic             out_vld_reg, out_vld_next;
    logic [1:0]       out_kind_reg;
    logic [3:0]       out_label_reg;
    logic [15:0]      out_col_reg;
    logic [15:0]      out_row_reg;
    logic [23:0]      out_rgb_reg;
    logic             out_load;

    // Memories
    logic [23:0]      pix_mem [MAX_PIXELS];
    logic [LW-1:0]    lbl_mem [MAX_PIXELS];
    logic [23:0]      pix_rd_reg;
    logic [LW-1:0]    lbl_rd_reg;

    // Cell row
    kmc_pkg::srch_t   srch_bus [MAX_CLUSTERS+1];
    kmc_pkg::acc_t    acc_bus  [MAX_CLUSTERS+1];
    logic [23:0]      cent_arr [MAX_CLUSTERS];
    logic [CNT_W-1:0] cnt_arr  [MAX_CLUSTERS];
    logic [SUM_W-1:0] sum_arr  [MAX_CLUSTERS][3];
    logic             cells_clr;
    logic             upd_write;

    // Divider
    logic             div_start;
    logic [NW-1:0]    div_a;
    logic [DW-1:0]    div_b;
    logic             div_busy;
    logic             div_done;
    logic [NW-1:0]    div_q;
    logic [DW-1:0]    div_r;

    logic             feed_issue;
    logic             lbl_we;
    logic [PAW-1:0]   lbl_waddr;
    logic [LW-1:0]    lbl_wdata;
    logic [31:0]      lbl_wide;

    assign feed_issue = (state_reg == kmc_pkg::ST_FEED) && (feed_reg < npix);
    assign out_load   = (state_reg == kmc_pkg::ST_RESP) && (!out_vld_reg || m_axis_tready);
    assign cells_clr  = (state_reg == kmc_pkg::ST_PASS_INIT);
    assign upd_write  = (state_reg == kmc_pkg::ST_UPD_WAIT) && div_done && (ch_reg == 2'd2);
    assign s_axis_tready = (state_reg == kmc_pkg::ST_IDLE);

    // Pixel memory: written by loads, read by the pass feed
    always_ff @(posedge clk)
    begin
        if (in_acc && (in_act == kmc_pkg::ACT_LOAD_PIX) && (32'(in_idx) < MAX_PIXELS))
            pix_mem[PAW'(in_idx)] <= in_rgb;
        pix_rd_reg <= pix_mem[feed_reg[PAW-1:0]];
    end

    // Label memory: cleared after reset, written at the end of the search lane
    always_comb
    begin
        if (state_reg == kmc_pkg::ST_CLEAR)
        begin
            lbl_we    = 1'b1;
            lbl_waddr = clr_addr_reg;
            lbl_wdata = '0;
        end
        else
        begin
            lbl_we    = srch_bus[MAX_CLUSTERS].vld;
            lbl_waddr = srch_bus[MAX_CLUSTERS].addr[PAW-1:0];
            lbl_wdata = srch_bus[MAX_CLUSTERS].label[LW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lbl_we)
            lbl_mem[lbl_waddr] <= lbl_wdata;
        lbl_rd_reg <= lbl_mem[PAW'(in_idx)];
    end

    // Pixel read pipe into the head of the cell row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= feed_issue;
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= feed_reg[PAW-1:0];
    end

    assign srch_bus[0] = '{vld: rd_vld_reg, addr: kmc_pkg::ADDR_W'(rd_addr_reg),
                           rgb: pix_rd_reg, dsq: '0, label: '0};
    assign acc_bus[0]  = '{vld: srch_bus[MAX_CLUSTERS].vld,
                           label: srch_bus[MAX_CLUSTERS].label,
                           rgb: srch_bus[MAX_CLUSTERS].rgb};

    for (genvar c = 0; c < MAX_CLUSTERS; c++)
    begin : g_cell
        logic cent_we;
        assign cent_we =
            (in_acc && (in_act == kmc_pkg::ACT_LOAD_CENT) && (32'(in_idx) == c)) ||
            (upd_write && (32'(u_reg) == c));

        kmc_cell #(
            .CNT_W (CNT_W),
            .SUM_W (SUM_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cell_idx     (kmc_pkg::LBL_W'(c)),
            .active_count (kk),
            .clr          (cells_clr),
            .cent_we      (cent_we),
            .cent_wdata   (upd_write ? newc_next : in_rgb),
            .srch_in      (srch_bus[c]),
            .srch_out     (srch_bus[c+1]),
            .acc_in       (acc_bus[c]),
            .acc_out      (acc_bus[c+1]),
            .centroid     (cent_arr[c]),
            .member_cnt   (cnt_arr[c]),
            .sum_r        (sum_arr[c][0]),
            .sum_g        (sum_arr[c][1]),
            .sum_b        (sum_arr[c][2])
        );
    end

    // Shared divider: centroid means and pixel column/row
    always_comb
    begin
        div_start = ((state_reg == kmc_pkg::ST_RD_LBL) && (image_width_reg != '0)) ||
                    (state_reg == kmc_pkg::ST_UPD_START);
        if (state_reg == kmc_pkg::ST_RD_LBL)
        begin
            div_a = NW'(idx_reg);
            div_b = DW'(image_width_reg);
        end
        else
        begin
            div_a = NW'(sum_arr[u_reg[LW-1:0]][ch_reg]);
            div_b = DW'(cnt_arr[u_reg[LW-1:0]]);
        end
    end

    kmc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kmc_pkg::ST_CLEAR:
                if (clr_addr_reg == PAW'(MAX_PIXELS - 1))
                    state_next = kmc_pkg::ST_IDLE;
            kmc_pkg::ST_IDLE:
                if (in_acc)
                begin
                    case (in_act)
                        kmc_pkg::ACT_RUN:
                            state_next = (iteration_limit_reg == '0) ?
                                         kmc_pkg::ST_RESP : kmc_pkg::ST_PASS_INIT;
                        kmc_pkg::ACT_READ_PIX:  state_next = kmc_pkg::ST_RD_LBL;
                        kmc_pkg::ACT_READ_CENT: state_next = kmc_pkg::ST_RESP;
                        default: ;
                    endcase
                end
            kmc_pkg::ST_RD_LBL:
                state_next = (image_width_reg == '0) ? kmc_pkg::ST_RESP
                                                     : kmc_pkg::ST_RD_DIV;
            kmc_pkg::ST_RD_DIV:
                if (div_done)
                    state_next = kmc_pkg::ST_RESP;
            kmc_pkg::ST_PASS_INIT:
                state_next = kmc_pkg::ST_FEED;
            kmc_pkg::ST_FEED:
                if (!feed_issue)
                    state_next = kmc_pkg::ST_DRAIN;
            kmc_pkg::ST_DRAIN:
                if (drain_reg == DRN_W'(DRAIN_CYC))
                    state_next = kmc_pkg::ST_UPD_SEL;
            kmc_pkg::ST_UPD_SEL:
                if (u_reg >= kk)
                    state_next = (iter_reg + 8'd1 == iteration_limit_reg) ?
                                 kmc_pkg::ST_RESP : kmc_pkg::ST_PASS_INIT;
                else if (cnt_arr[u_reg[LW-1:0]] != '0)
                    state_next = kmc_pkg::ST_UPD_START;
            kmc_pkg::ST_UPD_START:
                state_next = kmc_pkg::ST_UPD_WAIT;
            kmc_pkg::ST_UPD_WAIT:
                if (div_done)
                    state_next = (ch_reg == 2'd2) ? kmc_pkg::ST_UPD_SEL
                                                  : kmc_pkg::ST_UPD_START;
            kmc_pkg::ST_RESP:
                if (out_load)
                    state_next = kmc_pkg::ST_IDLE;
            default:
                state_next = kmc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result updates
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        feed_next      = feed_reg;
        drain_next     = drain_reg;
        iter_next      = iter_reg;
        u_next         = u_reg;
        ch_next        = ch_reg;
        idx_next       = idx_reg;
        newc_next      = newc_reg;
        res_kind_next  = res_kind_reg;
        res_label_next = res_label_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_rgb_next   = res_rgb_reg;
        lbl_wide       = 32'(lbl_rd_reg);
        case (state_reg)
            kmc_pkg::ST_CLEAR:
                clr_addr_next = clr_addr_reg + 1'b1;
            kmc_pkg::ST_IDLE:
                if (in_acc)
                begin
                    idx_next       = in_idx;
                    iter_next      = '0;
                    res_label_next = '0;
                    res_col_next   = '0;
                    res_row_next   = '0;
                    res_rgb_next   = '0;
                    case (in_act)
                        kmc_pkg::ACT_RUN:
                            res_kind_next = kmc_pkg::KIND_DONE;
                        kmc_pkg::ACT_READ_PIX:
                            res_kind_next = kmc_pkg::KIND_LABEL;
                        kmc_pkg::ACT_READ_CENT:
                        begin
                            res_kind_next = kmc_pkg::KIND_COLOR;
                            if (32'(in_idx) < MAX_CLUSTERS)
                                res_rgb_next = cent_arr[in_idx[LW-1:0]];
                        end
                        default: ;
                    endcase
                end
            kmc_pkg::ST_RD_LBL:
            begin
                res_label_next = (32'(idx_reg) < MAX_PIXELS) ? lbl_wide[3:0] : 4'd0;
                res_col_next   = idx_reg;
                res_row_next   = '0;
            end
            kmc_pkg::ST_RD_DIV:
                if (div_done)
                begin
                    res_col_next = div_r[15:0];
                    res_row_next = div_q[15:0];
                end
            kmc_pkg::ST_PASS_INIT:
                feed_next = '0;
            kmc_pkg::ST_FEED:
            begin
                drain_next = '0;
                if (feed_issue)
                    feed_next = feed_reg + 1'b1;
            end
            kmc_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                u_next     = '0;
            end
            kmc_pkg::ST_UPD_SEL:
            begin
                ch_next = '0;
                if (u_reg >= kk)
                    iter_next = iter_reg + 8'd1;
                else if (cnt_arr[u_reg[LW-1:0]] == '0)
                    u_next = u_reg + 1'b1;
            end
            kmc_pkg::ST_UPD_WAIT:
                if (div_done)
                begin
                    case (ch_reg)
                        2'd0:    newc_next[23:16] = div_q[7:0];
                        2'd1:    newc_next[15:8]  = div_q[7:0];
                        default: newc_next[7:0]   = div_q[7:0];
                    endcase
                    if (ch_reg == 2'd2)
                        u_next = u_reg + 1'b1;
                    else
                        ch_next = ch_reg + 2'd1;
                end
            default: ;
        endcase
    end

    // Output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
            out_vld_next = 1'b1;
        else if (m_axis_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= kmc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        feed_reg      <= feed_next;
        drain_reg     <= drain_next;
        iter_reg      <= iter_next;
        u_reg         <= u_next;
        ch_reg        <= ch_next;
        idx_reg       <= idx_next;
        newc_reg      <= newc_next;
        res_kind_reg  <= res_kind_next;
        res_label_reg <= res_label_next;
        res_col_reg   <= res_col_next;
        res_row_reg   <= res_row_next;
        res_rgb_reg   <= res_rgb_next;
        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_label_reg <= res_label_reg;
            out_col_reg   <= res_col_reg;
            out_row_reg   <= res_row_reg;
            out_rgb_reg   <= res_rgb_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {4'd0, out_rgb_reg[7:0], out_rgb_reg[15:8], out_rgb_reg[23:16],
                            out_row_reg, out_col_reg, out_label_reg};

    // Checks
    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_lbl_write_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        srch_bus[MAX_CLUSTERS].vld |->
            (state_reg == kmc_pkg::ST_FEED) || (state_reg == kmc_pkg::ST_DRAIN))
        else $error("search lane result outside a pass");

    a_acc_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        acc_bus[MAX_CLUSTERS].vld |->
            (state_reg == kmc_pkg::ST_FEED) || (state_reg == kmc_pkg::ST_DRAIN))
        else $error("accumulate lane busy after drain");

    a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == kmc_pkg::ST_IDLE) && out_vld_reg)
        else $error("result load did not complete");

endmodule

// ----- bench/kmc_checker.sv -----
// Checker for the k-means color clustering unit: watches the config port and
// both stream channels, predicts every result and compares it with the output.
module kmc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // item_index, in_red, in_green, in_blue
    input  logic [2:0]  s_axis_tuser,  // action
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,  // cluster_label, pixel_column, pixel_row,
                                       // out_red, out_green, out_blue, zero pad
    input  logic [1:0]  m_axis_tuser,  // result_kind
    output int          fail_count,
    output int          outstanding
);

    localparam int NPIX  = 65536;
    localparam int NCENT = 16;

    typedef struct {
        kmc_pkg::kind_t kind;
        logic [3:0] label;
        logic [15:0] column;
        logic [15:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } cluster_result_t;

    // Model copy of the block's memories and registers
    logic [23:0] pixel_mem [NPIX];
    logic [3:0]  label_mem [NPIX];
    logic [23:0] centroid_mem [NCENT];
    logic [4:0]  num_clusters;
    logic [7:0]  num_passes;
    logic [16:0] row_width;
    logic [16:0] num_pixels;

    cluster_result_t pending_results [$];

    assign outstanding = pending_results.size();

    initial
    begin
        fail_count = 0;
        for (int i = 0; i < NPIX; i++)
        begin
            pixel_mem[i] = '0;
            label_mem[i] = '0;
        end
        for (int c = 0; c < NCENT; c++)
            centroid_mem[c] = '0;
        num_clusters = 5'd4;
        num_passes   = 8'd10;
        row_width    = 17'd256;
        num_pixels   = 17'h10000;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // One Lloyd pass: nearest centroid per pixel, then floor-mean update
    task automatic lloyd_pass(input int k, input int n);
        int     members [NCENT];
        longint sums [NCENT*3];
        int     best, best_d, d, df;
        for (int c = 0; c < NCENT; c++)
        begin
            members[c] = 0;
            for (int ch = 0; ch < 3; ch++)
                sums[c*3+ch] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            best = 0;
            best_d = 0;
            for (int c = 0; c < k; c++)
            begin
                d = 0;
                for (int ch = 0; ch < 3; ch++)
                begin
                    df = int'(pixel_mem[i][16-8*ch +: 8]) - int'(centroid_mem[c][16-8*ch +: 8]);
                    d += df * df;
                end
                if (c == 0 || d < best_d)
                begin
                    best_d = d;
                    best = c;
                end
            end
            label_mem[i] = best[3:0];
            members[best]++;
            for (int ch = 0; ch < 3; ch++)
                sums[best*3+ch] += pixel_mem[i][16-8*ch +: 8];
        end
        // empty clusters keep their color
        for (int c = 0; c < k; c++)
            if (members[c] != 0)
                for (int ch = 0; ch < 3; ch++)
                    centroid_mem[c][16-8*ch +: 8] = 8'(sums[c*3+ch] / members[c]);
    endtask

    // Predict the result of one accepted request
    task automatic predict_request(input logic [2:0] act, input logic [39:0] payload);
        cluster_result_t r;
        logic [15:0] idx;
        int k, n, w;
        idx = payload[15:0];
        r = '{kmc_pkg::KIND_LABEL, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0};
        case (act)
            kmc_pkg::ACT_LOAD_PIX:
                pixel_mem[idx] = {payload[23:16], payload[31:24], payload[39:32]};
            kmc_pkg::ACT_LOAD_CENT:
                if (idx < NCENT)
                    centroid_mem[idx] = {payload[23:16], payload[31:24], payload[39:32]};
            kmc_pkg::ACT_RUN:
            begin
                k = num_clusters;
                n = num_pixels;
                if (k == 0) k = 1;
                if (k > NCENT) k = NCENT;
                if (n > NPIX) n = NPIX;
                for (int t = 0; t < num_passes; t++)
                    lloyd_pass(k, n);
                r.kind = kmc_pkg::KIND_DONE;
                pending_results.insert(pending_results.size(), r);
            end
            kmc_pkg::ACT_READ_PIX:
            begin
                w = row_width;
                r.kind  = kmc_pkg::KIND_LABEL;
                r.label = label_mem[idx];
                r.column = (w == 0) ? idx : 16'(int'(idx) % w);
                r.row    = (w == 0) ? 16'd0 : 16'(int'(idx) / w);
                pending_results.insert(pending_results.size(), r);
            end
            kmc_pkg::ACT_READ_CENT:
            begin
                r.kind = kmc_pkg::KIND_COLOR;
                if (idx < NCENT)
                    {r.red, r.green, r.blue} = centroid_mem[idx];
                pending_results.insert(pending_results.size(), r);
            end
            default: ;
        endcase
    endtask

    // Config writes, requests and results, all sampled at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    kmc_pkg::REG_CLUSTER_COUNT:   num_clusters = cfg_wdata[4:0];
                    kmc_pkg::REG_ITERATION_LIMIT: num_passes   = cfg_wdata[7:0];
                    kmc_pkg::REG_IMAGE_WIDTH:     row_width    = cfg_wdata;
                    kmc_pkg::REG_PIXEL_TOTAL:     num_pixels   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result, kind", m_axis_tuser, 0);
                else
                begin
                    cluster_result_t w;
                    w = pending_results.pop_front();
                    if (m_axis_tuser != w.kind)
                        report_mismatch("result_kind", m_axis_tuser, w.kind);
                    if (m_axis_tdata[3:0] != w.label)
                        report_mismatch("cluster_label", m_axis_tdata[3:0], w.label);
                    if (m_axis_tdata[19:4] != w.column)
                        report_mismatch("pixel_column", m_axis_tdata[19:4], w.column);
                    if (m_axis_tdata[35:20] != w.row)
                        report_mismatch("pixel_row", m_axis_tdata[35:20], w.row);
                    if (m_axis_tdata[43:36] != w.red)
                        report_mismatch("out_red", m_axis_tdata[43:36], w.red);
                    if (m_axis_tdata[51:44] != w.green)
                        report_mismatch("out_green", m_axis_tdata[51:44], w.green);
                    if (m_axis_tdata[59:52] != w.blue)
                        report_mismatch("out_blue", m_axis_tdata[59:52], w.blue);
                    if (m_axis_tdata[63:60] != '0)
                        report_mismatch("tdata pad", m_axis_tdata[63:60], 0);
                end
            end
        end
    end

endmodule

// ----- bench/kmeans_color_clustering_unit_tb.sv -----
module kmeans_color_clustering_unit_tb;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam logic [2:0]  ACT_SPARE_LO = 3'd5;
    localparam logic [2:0]  ACT_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // item_index, in_red, in_green, in_blue
    logic [2:0]  s_axis_tuser;  // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;  // cluster_label, pixel_column, pixel_row,
                                // out_red, out_green, out_blue, zero pad
    logic [1:0]  m_axis_tuser;  // result_kind

    int fail_count;
    int outstanding;
    int cycle_count;
    int gap_pct;
    int stall_pct;

    // which centroids hold a defined color
    bit centroid_loaded [16];

    kmeans_color_clustering_unit uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    kmc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("kmeans_color_clustering_unit verification failed");
            $finish;
        end
    end

    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin gap_pct = 57; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 57; end
            3:       begin gap_pct = 12; stall_pct = 12; end
            default: begin gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Issue one request and hold it until accepted
    task automatic send_request(input logic [2:0] act, input logic [15:0] idx,
                                input logic [23:0] rgb);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16], idx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (act == kmc_pkg::ACT_LOAD_CENT && idx < 16)
            centroid_loaded[idx] = 1'b1;
    endtask

    // Register write once the block has drained
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic write_all_regs(input int k, input int iters, input int w, input int n);
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 17'(k));
        write_reg(kmc_pkg::REG_ITERATION_LIMIT, 17'(iters));
        write_reg(kmc_pkg::REG_IMAGE_WIDTH, 17'(w));
        write_reg(kmc_pkg::REG_PIXEL_TOTAL, 17'(n));
    endtask

    // Centroid read that never touches an unwritten entry
    task automatic read_centroid_safe(input int idx);
        if (idx < 16 && !centroid_loaded[idx])
            idx = 16 + $urandom_range(65519);
        send_request(kmc_pkg::ACT_READ_CENT, 16'(idx), 24'h0);
    endtask

    initial
    begin
        int n, k, iters, w, pick, idx;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        cycle_count = 0;
        set_idle_mode(0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: ties to the lowest index, an empty cluster, extreme colors
        write_all_regs(2, 3, 4, 6);
        send_request(kmc_pkg::ACT_LOAD_PIX, 16'd0, 24'h000000);
        send_request(kmc_pkg::ACT_LOAD_PIX, 16'd1, 24'hFFFFFF);
        send_request(kmc_pkg::ACT_LOAD_PIX, 16'd2, 24'h102030);
        send_request(kmc_pkg::ACT_LOAD_PIX, 16'd3, 24'hFF0000);
        send_request(kmc_pkg::ACT_LOAD_PIX, 16'd4, 24'h00FF00);
        send_request(kmc_pkg::ACT_LOAD_PIX, 16'd5, 24'h0000FF);
        send_request(kmc_pkg::ACT_LOAD_CENT, 16'd0, 24'h808080);
        send_request(kmc_pkg::ACT_LOAD_CENT, 16'd1, 24'h808080);
        send_request(kmc_pkg::ACT_LOAD_CENT, 16'd20, 24'hABCDEF);
        send_request(ACT_SPARE_LO, 16'd3, 24'h123456);
        send_request(ACT_SPARE_HI, 16'hFFFF, 24'hFFFFFF);
        send_request(kmc_pkg::ACT_RUN, 16'd0, 24'h0);
        send_request(kmc_pkg::ACT_READ_PIX, 16'd0, 24'h0);
        send_request(kmc_pkg::ACT_READ_PIX, 16'd5, 24'h0);
        send_request(kmc_pkg::ACT_READ_PIX, 16'hFFFF, 24'h0);
        send_request(kmc_pkg::ACT_READ_CENT, 16'd0, 24'h0);
        send_request(kmc_pkg::ACT_READ_CENT, 16'd1, 24'h0);
        send_request(kmc_pkg::ACT_READ_CENT, 16'd20, 24'h0);
        // zero passes still answers; a zero cluster count clamps to one, an out-of-range one to max
        write_all_regs(0, 0, 0, 0);
        send_request(kmc_pkg::ACT_RUN, 16'd0, 24'h0);
        send_request(kmc_pkg::ACT_READ_PIX, 16'hBEEF, 24'h0);
        write_all_regs(31, 255, 1, 1);
        for (int c = 0; c < 16; c++)
            send_request(kmc_pkg::ACT_LOAD_CENT, 16'(c), {8'(c*16), 8'(255-c*16), 8'(c)});
        send_request(kmc_pkg::ACT_RUN, 16'd0, 24'h0);
        send_request(kmc_pkg::ACT_READ_CENT, 16'd0, 24'h0);
        send_request(kmc_pkg::ACT_READ_PIX, 16'hFFFF, 24'h0);
        write_all_regs(16, 1, 65536, 65536);
        send_request(kmc_pkg::ACT_READ_PIX, 16'hFFFF, 24'h0);
        send_request(kmc_pkg::ACT_READ_CENT, 16'd15, 24'h0);

        // Random epochs: fresh image and centroids, then a mixed request stream
        for (int epoch = 0; epoch < 13; epoch++)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(33, 48) : $urandom_range(1, 16);
            k = ($urandom_range(9) == 0) ? 16 : $urandom_range(1, 6);
            iters = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
            pick = $urandom_range(3);
            w = (pick == 0) ? 1 : (pick == 1) ? 65536 : $urandom_range(1, 300);
            write_all_regs(k, iters, w, n);
            set_idle_mode(epoch % 4);
            for (int i = 0; i < n; i++)
                send_request(kmc_pkg::ACT_LOAD_PIX, 16'(i), 24'($urandom));
            for (int c = 0; c < k; c++)
                send_request(kmc_pkg::ACT_LOAD_CENT, 16'(c), 24'($urandom));
            for (int j = 0; j < 17; j++)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                    send_request(kmc_pkg::ACT_LOAD_PIX, 16'($urandom), 24'($urandom));
                else if (pick < 25)
                    send_request(kmc_pkg::ACT_LOAD_CENT, 16'($urandom_range(19)),
                                 24'($urandom));
                else if (pick < 60)
                begin
                    idx = $urandom_range(1) ? $urandom_range(n - 1) : $urandom_range(65535);
                    send_request(kmc_pkg::ACT_READ_PIX, 16'(idx), 24'($urandom));
                end
                else if (pick < 80)
                    read_centroid_safe($urandom_range(31));
                else if (pick < 85)
                    send_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                                 16'($urandom), 24'($urandom));
                else
                    send_request(kmc_pkg::ACT_RUN, 16'($urandom), 24'($urandom));
            end
            send_request(kmc_pkg::ACT_RUN, 16'd0, 24'h0);
            for (int i = 0; i < n; i++)
                send_request(kmc_pkg::ACT_READ_PIX, 16'(i), 24'h0);
            for (int c = 0; c < k; c++)
                send_request(kmc_pkg::ACT_READ_CENT, 16'(c), 24'h0);
        end

        // Drain and give the verdict
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("kmeans_color_clustering_unit verification clean");
        else
            $display("kmeans_color_clustering_unit verification failed");
        $finish;
    end

endmodule

// ----- kmeans_color_clustering_unit.f -----
rtl/kmc_pkg.sv
rtl/kmc_div.sv
rtl/kmc_cell.sv
rtl/kmeans_color_clustering_unit.sv
bench/kmc_checker.sv
bench/kmeans_color_clustering_unit_tb.sv
